@@ src/bpa_pkg.sv @@
package bpa_pkg;

	localparam int PAGE_W  = 13;
	localparam int INDEX_W = 12;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_OOM = 1'b1;

	localparam logic [PAGE_W-1:0] TOTAL_PAGES_RST = 13'd4096;

	typedef struct packed {
		logic               mode;
		logic [INDEX_W-1:0] page_index;
		logic [PAGE_W-1:0]  page_count;
	} in_item_t;

	typedef struct packed {
		logic              status;
		logic [PAGE_W-1:0] first_page;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic init_step;
		logic load;
		logic scan_step;
		logic scan_end;
		logic mark_step;
		logic emit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic init_last;
		logic scan_stop;
		logic mark_done;
		logic out_free;
	} sts_t;

endpackage

@@ src/bpa_ram.sv @@
module bpa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ src/bpa_ctrl.sv @@
module bpa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_mode,
	output logic          in_stall,
	input  bpa_pkg::sts_t sts,
	output bpa_pkg::cmd_t cmd
);

	typedef enum logic [5:0] {
		ST_INIT = 6'b000001,
		ST_IDLE = 6'b000010,
		ST_SCAN = 6'b000100,
		ST_MARK = 6'b001000,
		ST_DONE = 6'b010000,
		ST_SPARE = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_INIT: begin
				cmd.init_step = 1'b1;
				if (sts.init_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					state_d  = (in_mode == bpa_pkg::MODE_FREE) ? ST_MARK : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.scan_stop) begin
					cmd.scan_end = 1'b1;
					state_d      = ST_MARK;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			ST_MARK: begin
				if (sts.mark_done) begin
					state_d = ST_DONE;
				end else begin
					cmd.mark_step = 1'b1;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ src/bpa_dpath.sv @@
module bpa_dpath #(
	parameter int MAX_PAGES = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bpa_pkg::cmd_t                       cmd,
	output bpa_pkg::sts_t                       sts,
	input  bpa_pkg::in_item_t                   in_item,
	input  logic                                cfg_we,
	input  logic [bpa_pkg::PAGE_W-1:0]          cfg_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output bpa_pkg::out_item_t                  out_item
);

	localparam int AW = $clog2(MAX_PAGES);
	localparam int PW = bpa_pkg::PAGE_W;
	// a free run may reach past 8191 before the map end stops it
	localparam int WW = PW + 1;
	localparam logic [AW-1:0] INIT_LAST = AW'(MAX_PAGES - 1);

	logic [PW-1:0]       total_q;
	logic [PW-1:0]       cur_q;
	logic [PW-1:0]       run_q;
	logic [PW-1:0]       cnt_q;
	logic [WW-1:0]       wptr_q;
	logic [PW-1:0]       rem_q;
	logic                mode_q;
	logic                dv_q;
	logic [AW-1:0]       init_q;
	logic                out_valid_q;
	bpa_pkg::out_item_t  res_q;

	logic [PW-1:0] limit;
	logic [PW-1:0] cur_inc;
	logic [PW-1:0] start;
	logic          run_hit;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [0:0]    ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [0:0]    ram_rdata;

	assign limit   = (32'(total_q) < 32'(MAX_PAGES)) ? total_q : PW'(MAX_PAGES);
	assign cur_inc = cur_q + PW'(1);
	assign start   = cur_q - run_q;
	assign run_hit = (run_q == cnt_q);

	assign sts.init_last = (init_q == INIT_LAST);
	assign sts.scan_stop = run_hit || (cur_q >= limit);
	assign sts.mark_done = (rem_q == '0) || (32'(wptr_q) >= 32'(MAX_PAGES));
	assign sts.out_free  = !out_valid_q || !out_stall;

	// clearing pass fills with ones; alloc marks ones, free marks zeros
	assign ram_we    = cmd.init_step || cmd.mark_step;
	assign ram_waddr = cmd.init_step ? init_q : AW'(wptr_q);
	assign ram_wdata = cmd.init_step ? 1'b1 : (mode_q == bpa_pkg::MODE_ALLOC);
	// read one page ahead so one page is consumed per cycle
	assign ram_raddr = dv_q ? AW'(cur_inc) : AW'(cur_q);

	bpa_ram #(
		.WIDTH(1),
		.DEPTH(MAX_PAGES)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= bpa_pkg::TOTAL_PAGES_RST;
			cur_q       <= '0;
			dv_q        <= 1'b0;
			init_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				total_q <= cfg_data;
			end
			if (cmd.init_step) begin
				init_q <= init_q + AW'(1);
			end
			if (cmd.load) begin
				dv_q <= 1'b0;
				if (in_item.mode == bpa_pkg::MODE_FREE) begin
					cur_q <= PW'(in_item.page_index);
				end
			end
			if (cmd.scan_step) begin
				dv_q <= 1'b1;
				if (dv_q) begin
					cur_q <= cur_inc;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q          <= in_item.mode;
			cnt_q           <= in_item.page_count;
			run_q           <= '0;
			wptr_q          <= WW'(in_item.page_index);
			rem_q           <= (in_item.mode == bpa_pkg::MODE_FREE) ? in_item.page_count : '0;
			res_q.status     <= bpa_pkg::STATUS_OK;
			res_q.first_page <= '0;
		end
		if (cmd.scan_step && dv_q) begin
			run_q <= ram_rdata[0] ? '0 : run_q + PW'(1);
		end
		if (cmd.scan_end) begin
			if (run_hit) begin
				wptr_q           <= {1'b0, start};
				rem_q            <= run_q;
				res_q.status     <= bpa_pkg::STATUS_OK;
				res_q.first_page <= start;
			end else begin
				rem_q            <= '0;
				res_q.status     <= bpa_pkg::STATUS_OOM;
				res_q.first_page <= '0;
			end
		end
		if (cmd.mark_step) begin
			wptr_q <= wptr_q + WW'(1);
			rem_q  <= rem_q - PW'(1);
		end
		if (cmd.emit) begin
			out_item <= res_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ src/bitmap_page_allocator_unit.sv @@
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+------------------------------------
// in       | input     | in_valid / in_stall    | in_item  (mode, page_index, page_count)
// out      | output    | out_valid / out_stall  | out_item (status, first_page)
// cfg      | input     | cfg_valid / cfg_ready  | cfg_data (total_pages)
//
// One item at a time. Allocate: accept, a read issue (none when the scan
// stops at once), the scan page by page, the scan end, marking page by page,
// then the hand-off to the output register.
// Free: accept, clearing page by page (up to the map end), then the hand-off.
// After reset a clearing pass sets every used bit, with in_stall high;
// config writes are taken at any time (cfg_ready tied high).
// A stalled result sits in the output register while the next item is taken.
module bitmap_page_allocator_unit #(
	parameter int MAX_PAGES = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input items
	input  logic                                in_valid,
	output logic                                in_stall,
	input  bpa_pkg::in_item_t                   in_item,
	// result items
	output logic                                out_valid,
	input  logic                                out_stall,
	output bpa_pkg::out_item_t                  out_item,
	// total_pages register write
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bpa_pkg::PAGE_W-1:0]          cfg_data
);

	bpa_pkg::cmd_t cmd;
	bpa_pkg::sts_t sts;

	// register write needs no back-pressure
	assign cfg_ready = 1'b1;

	// sequencer: clear pass, scan, mark, hand-off
	bpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_mode  (in_item.mode),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// used map RAM, next-fit cursor, run counter, result register
	bpa_dpath #(
		.MAX_PAGES(MAX_PAGES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_item   (in_item),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

	localparam int MAP_PAGES      = 4096;
	// worst run: directed part plus the two full-map phases, the rest with totals of
	// at most 512 pages, plus stalls; taken ~5x over
	localparam int CYCLE_LIMIT    = 4_000_000;
	localparam int HOLDOFF_CYCLES = 600;
	localparam int PHASES         = 9;

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        in_valid  = 1'b0;
	logic                        in_stall;
	bpa_pkg::in_item_t           in_item   = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	bpa_pkg::out_item_t          out_item;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [bpa_pkg::PAGE_W-1:0]  cfg_data  = '0;

	// shadow allocator state: used bit per page, next-fit cursor, page total register
	bit                          used_bits [MAP_PAGES];
	int unsigned                 cursor_page;
	logic [bpa_pkg::PAGE_W-1:0]  page_total = bpa_pkg::TOTAL_PAGES_RST;

	bpa_pkg::in_item_t           request_backlog [$];	// items waiting to be offered
	bpa_pkg::out_item_t          awaited_grants [$];	// predicted results, oldest first

	int unsigned        send_gap_pct   = 0;
	int unsigned        sink_stall_pct = 0;
	bit                 holdoff_armed  = 1'b0;
	int                 holdoff_left;
	int                 mismatch_count = 0;
	int                 grants_seen    = 0;
	int                 cycle_count    = 0;

	int unsigned        phase_total [PHASES];
	int unsigned        phase_len [PHASES];

	bitmap_page_allocator_unit #(
		.MAX_PAGES(MAP_PAGES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Apply one item to the shadow state and return the result it should give.
	// Free clears up to the map end and parks the cursor at the run start.
	// Allocate scans from the cursor up to min(total, map size), a used page
	// restarting the run; no run found leaves the map alone, status out of memory.
	function automatic bpa_pkg::out_item_t next_fit_outcome(input bpa_pkg::in_item_t req);
		bpa_pkg::out_item_t res;
		int unsigned        lim;
		int unsigned        run;
		int unsigned        start;
		int unsigned        i;
		res.status     = bpa_pkg::STATUS_OK;
		res.first_page = '0;
		if (req.mode == bpa_pkg::MODE_FREE) begin
			for (i = 0; i < 32'(req.page_count); i++)
				if (32'(req.page_index) + i < MAP_PAGES)
					used_bits[32'(req.page_index) + i] = 1'b0;
			cursor_page = 32'(req.page_index);
		end else begin
			lim = (32'(page_total) < MAP_PAGES) ? 32'(page_total) : MAP_PAGES;
			run = 0;
			// stops one page past the run, or at the limit
			while (cursor_page < lim && run != 32'(req.page_count)) begin
				run = used_bits[cursor_page] ? 0 : run + 1;
				cursor_page++;
			end
			if (run == 32'(req.page_count)) begin
				// zero length lands here too: first page is the cursor, nothing marked
				start = cursor_page - run;
				for (i = 0; i < run; i++)
					used_bits[start + i] = 1'b1;
				res.first_page = start[bpa_pkg::PAGE_W-1:0];
			end else begin
				res.status = bpa_pkg::STATUS_OOM;
			end
		end
		return res;
	endfunction

	// Mostly ordinary traffic: small allocations and frees inside the managed
	// range, so holes open and get reused; the rest is stray frees anywhere
	// in the map and oversized allocations that mostly run out of memory.
	function automatic bpa_pkg::in_item_t random_request(input int unsigned lim);
		bpa_pkg::in_item_t req;
		int unsigned       roll;
		int unsigned       sub;
		roll = $urandom_range(0, 99);
		sub  = $urandom_range(0, 99);
		req.page_index = bpa_pkg::INDEX_W'($urandom_range(0, MAP_PAGES - 1));
		if (roll < 45) begin
			req.mode = bpa_pkg::MODE_ALLOC;
			if (sub < 5)
				req.page_count = '0;
			else if (sub < 80)
				req.page_count = bpa_pkg::PAGE_W'($urandom_range(1, 8));
			else
				req.page_count = bpa_pkg::PAGE_W'($urandom_range(9, 40));
		end else if (roll < 88) begin
			req.mode = bpa_pkg::MODE_FREE;
			if (lim != 0)
				req.page_index = bpa_pkg::INDEX_W'($urandom_range(0, lim - 1));
			req.page_count = (sub < 10) ? bpa_pkg::PAGE_W'($urandom_range(17, 64)) :
				bpa_pkg::PAGE_W'($urandom_range(1, 16));
		end else if (roll < 97) begin
			req.mode       = bpa_pkg::MODE_FREE;
			req.page_count = bpa_pkg::PAGE_W'($urandom_range(0, 32));
		end else begin
			req.mode       = bpa_pkg::MODE_ALLOC;
			req.page_count = bpa_pkg::PAGE_W'($urandom_range(0, 8191));
		end
		return req;
	endfunction

	task automatic queue_request(input logic mode, input int unsigned idx, input int unsigned cnt);
		bpa_pkg::in_item_t req;
		req.mode       = mode;
		req.page_index = idx[bpa_pkg::INDEX_W-1:0];
		req.page_count = cnt[bpa_pkg::PAGE_W-1:0];
		request_backlog.push_back(req);
	endtask

	task automatic note_mismatch(input string msg);
		// printing capped so a badly broken block cannot flood the log
		if (mismatch_count < 50)
			$display("tb: MISMATCH %s", msg);
		mismatch_count++;
	endtask

	task automatic check_grant(input bpa_pkg::out_item_t got);
		bpa_pkg::out_item_t want;
		grants_seen++;
		if (awaited_grants.size() == 0) begin
			note_mismatch($sformatf("result %0d unexpected: status %0d page %0d",
				grants_seen, got.status, got.first_page));
		end else begin
			want = awaited_grants.pop_front();
			if (got.status !== want.status)
				note_mismatch($sformatf("result %0d status %0d, want %0d",
					grants_seen, got.status, want.status));
			if (got.first_page !== want.first_page)
				note_mismatch($sformatf("result %0d first_page %0d, want %0d",
					grants_seen, got.first_page, want.first_page));
		end
	endtask

	// Block idle: nothing queued or offered, every result back.
	task automatic wait_quiet();
		do
			@(negedge clk);
		while (request_backlog.size() != 0 || in_valid || awaited_grants.size() != 0);
	endtask

	// Register write only with the block idle; every item gives a result,
	// so no extra settle time is needed. Returns on a falling edge.
	task automatic program_total(input logic [bpa_pkg::PAGE_W-1:0] total);
		wait_quiet();
		@(posedge clk);
		cfg_valid  <= 1'b1;
		cfg_data   <= total;
		page_total  = total;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_phase(input int unsigned total, input int n,
			input int unsigned gap_pct, input int unsigned stall_pct);
		int unsigned lim;
		program_total(total[bpa_pkg::PAGE_W-1:0]);
		lim            = (total < MAP_PAGES) ? total : MAP_PAGES;
		send_gap_pct   = gap_pct;
		sink_stall_pct = stall_pct;
		repeat (n)
			request_backlog.push_back(random_request(lim));
	endtask

	// Sender: predicts each item as it is taken, holds a stalled item
	// unchanged, otherwise offers the next one unless idling this cycle.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				awaited_grants.push_back(next_fit_outcome(in_item));
			if (in_valid && in_stall) begin
				// hold
			end else if (request_backlog.size() != 0 &&
					$urandom_range(0, 99) >= send_gap_pct) begin
				in_valid <= 1'b1;
				in_item  <= request_backlog.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: checks each taken result, stalls at random or during a hold-off.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				check_grant(out_item);
			out_stall <= (holdoff_left != 0) || ($urandom_range(0, 99) < sink_stall_pct);
		end
	end

	// Long receiver hold-off, counted here so the sender keeps offering.
	always @(posedge clk) begin
		if (!arst_n)
			holdoff_left <= 0;
		else if (holdoff_left != 0)
			holdoff_left <= holdoff_left - 1;
		else if (holdoff_armed)
			holdoff_left <= HOLDOFF_CYCLES;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		foreach (used_bits[p])
			used_bits[p] = 1'b1;
		cursor_page = 0;
		// random phases: extremes of the total among them, full map kept short
		phase_total = '{64, 256, 8191, 100, 0, 33, 512, 4096, 1};
		phase_len   = '{250, 250, 20, 250, 20, 250, 250, 20, 60};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed, total at its reset value. Map starts all used.
		queue_request(bpa_pkg::MODE_ALLOC, 0, 1);	// nothing free: out of memory, cursor to end
		queue_request(bpa_pkg::MODE_ALLOC, 0, 0);	// zero length with cursor at the limit
		queue_request(bpa_pkg::MODE_FREE, 4095, 8191);	// run past the map end, only last page
		queue_request(bpa_pkg::MODE_ALLOC, 0, 1);	// run ending on the last page
		queue_request(bpa_pkg::MODE_FREE, 0, 4096);	// whole map free
		queue_request(bpa_pkg::MODE_ALLOC, 0, 4096);	// whole map taken
		queue_request(bpa_pkg::MODE_FREE, 0, 0);	// zero length: cursor only
		queue_request(bpa_pkg::MODE_ALLOC, 0, 0);	// zero length below the limit
		queue_request(bpa_pkg::MODE_FREE, 100, 50);
		queue_request(bpa_pkg::MODE_ALLOC, 0, 60);	// hole too short: fails, cursor at end
		queue_request(bpa_pkg::MODE_FREE, 0, 0);
		queue_request(bpa_pkg::MODE_ALLOC, 4095, 50);	// used pages restart the run, hole found
		queue_request(bpa_pkg::MODE_FREE, 4000, 200);	// clipped at the map end
		queue_request(bpa_pkg::MODE_ALLOC, 0, 8191);	// largest count
		queue_request(bpa_pkg::MODE_FREE, 4000, 0);
		queue_request(bpa_pkg::MODE_ALLOC, 0, 96);	// exactly fills to the end

		// total of zero: only zero length succeeds, cursor never moves forward
		program_total(13'd0);
		queue_request(bpa_pkg::MODE_ALLOC, 0, 0);
		queue_request(bpa_pkg::MODE_FREE, 10, 5);	// pages above the total are still cleared
		queue_request(bpa_pkg::MODE_ALLOC, 0, 0);
		queue_request(bpa_pkg::MODE_ALLOC, 0, 1);

		// total above the map: limit is the map size
		program_total(13'd8191);
		queue_request(bpa_pkg::MODE_ALLOC, 0, 5);
		queue_request(bpa_pkg::MODE_FREE, 2048, 4096);
		queue_request(bpa_pkg::MODE_ALLOC, 0, 2048);

		program_total(13'd1);
		queue_request(bpa_pkg::MODE_FREE, 0, 1);
		queue_request(bpa_pkg::MODE_ALLOC, 0, 1);
		queue_request(bpa_pkg::MODE_ALLOC, 0, 1);

		// idling pattern cycles: none, sender gaps, receiver stalls, both
		for (int ph = 0; ph < PHASES; ph++)
			run_phase(phase_total[ph], phase_len[ph],
				(ph % 4 == 1) ? 73 : (ph % 4 == 3) ? 33 : 0,
				(ph % 4 == 2) ? 73 : (ph % 4 == 3) ? 33 : 0);

		// receiver holds off while items keep coming, until the input stalls
		run_phase(64, 40, 0, 0);
		holdoff_armed = 1'b1;
		do
			@(negedge clk);
		while (holdoff_left == 0);
		holdoff_armed = 1'b0;

		wait_quiet();
		repeat (200) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
